// File: rtl/rcl_pkg.sv
// Shared types, codes and constants of the radio-control link frame parser.
`default_nettype none

package rcl_pkg;

  // Accepted address bytes
  localparam logic [7:0] ADDR_BROADCAST = 8'hEE;
  localparam logic [7:0] ADDR_RADIO     = 8'hEA;
  localparam logic [7:0] ADDR_FC        = 8'hC8;
  localparam logic [7:0] ADDR_RX        = 8'hEC;

  // Frame types
  localparam logic [7:0] TYPE_LIMIT      = 8'h7D;
  localparam logic [7:0] TYPE_CHANNELS   = 8'h16;
  localparam logic [7:0] TYPE_LINK_STATS = 8'h14;

  // CRC-8 generator, MSB first, init zero
  localparam logic [7:0] CRC_POLY = 8'hD5;

  // Channel packing: sixteen 11-bit values over 22 bytes
  localparam int         CH_BITS = 11;
  localparam logic [3:0] LAST_CH = 4'd15;

  localparam logic [31:0] ERR_MAX = 32'hFFFF_FFFF;

  // Result kind codes
  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_CHANNEL = 2'd1;
  localparam logic [1:0] KIND_STATS   = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_ADDR = 3'd1;
  localparam logic [2:0] ST_BAD_LEN  = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE = 3'd3;
  localparam logic [2:0] ST_BAD_CRC  = 3'd4;

  // Frame parse phase
  typedef enum logic [2:0] {
    PH_ADDR,
    PH_LEN,
    PH_TYPE,
    PH_PAYLOAD,
    PH_CRC
  } phase_t;

  // Top-level sequencer
  typedef enum logic [2:0] {
    S_IDLE,
    S_EMIT,
    S_STAT0,
    S_STAT1,
    S_STAT2,
    S_STAT_EMIT,
    S_CHAN
  } ctl_state_t;

  // Channel unpacker
  typedef enum logic [2:0] {
    U_IDLE,
    U_FETCH,
    U_LOAD,
    U_SHIFT,
    U_EMIT
  } up_state_t;

  // Command to the bit-serial CRC unit
  typedef struct packed {
    logic       start;
    logic       init;
    logic [7:0] data;
  } crc_cmd_t;

  // One unpacked channel offered to the output stage
  typedef struct packed {
    logic        valid;
    logic        last;
    logic [3:0]  index;
    logic [10:0] value;
  } chan_t;

  function automatic logic is_addr(input logic [7:0] b);
    return (b == ADDR_BROADCAST) || (b == ADDR_RADIO) || (b == ADDR_FC) || (b == ADDR_RX);
  endfunction

endpackage

`default_nettype wire

// File: rtl/rcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/rcl_crc8.sv
// Bit-serial CRC-8 unit: folds one byte into the running CRC, one bit per cycle.
`default_nettype none

module rcl_crc8
  import rcl_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire crc_cmd_t   cmd,
  output logic [7:0]      crc,
  output logic            busy
);

  logic [7:0] sh;
  logic [2:0] cnt;
  logic       fb;

  // feedback: CRC MSB against the next data bit, MSB first
  assign fb = crc[7] ^ sh[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      crc  <= '0;
    end else if (cmd.start) begin
      busy <= 1'b1;
      cnt  <= '0;
      sh   <= cmd.data;
      if (cmd.init) begin
        crc <= '0;
      end
    end else if (busy) begin
      crc  <= {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      sh   <= {sh[6:0], 1'b0};
      cnt  <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rcl_unpack.sv
// Bit-serial channel unpacker: streams payload bytes LSB first into 11-bit channels.
`default_nettype none

module rcl_unpack
  import rcl_pkg::*;
#(
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          res_ready,
  input  wire logic [7:0]    rd_data,
  output logic      [AW-1:0] rd_addr,
  output chan_t              chan,
  output logic               busy
);

  up_state_t   state, state_next;
  logic [4:0]  byte_idx, byte_idx_next;
  logic [7:0]  sh, sh_next;
  logic [2:0]  bit_cnt, bit_cnt_next;
  logic [10:0] acc, acc_next;
  logic [3:0]  acc_cnt, acc_cnt_next;
  logic [3:0]  ch_idx, ch_idx_next;
  logic        byte_done, byte_done_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= U_IDLE;
      byte_idx  <= '0;
      bit_cnt   <= '0;
      acc_cnt   <= '0;
      ch_idx    <= '0;
      byte_done <= 1'b0;
    end else begin
      state     <= state_next;
      byte_idx  <= byte_idx_next;
      bit_cnt   <= bit_cnt_next;
      acc_cnt   <= acc_cnt_next;
      ch_idx    <= ch_idx_next;
      byte_done <= byte_done_next;
    end
  end

  // bit shifters
  always_ff @(posedge clk) begin
    sh  <= sh_next;
    acc <= acc_next;
  end

  // sequencing: fetch a byte, shift its bits out, emit every eleventh bit
  always_comb begin
    state_next     = state;
    byte_idx_next  = byte_idx;
    sh_next        = sh;
    bit_cnt_next   = bit_cnt;
    acc_next       = acc;
    acc_cnt_next   = acc_cnt;
    ch_idx_next    = ch_idx;
    byte_done_next = byte_done;
    unique case (state)
      U_IDLE: begin
        if (start) begin
          byte_idx_next = '0;
          ch_idx_next   = '0;
          acc_cnt_next  = '0;
          state_next    = U_FETCH;
        end
      end
      U_FETCH: begin
        state_next = U_LOAD;
      end
      U_LOAD: begin
        sh_next        = rd_data;
        bit_cnt_next   = '0;
        byte_done_next = 1'b0;
        state_next     = U_SHIFT;
      end
      U_SHIFT: begin
        acc_next     = {sh[0], acc[10:1]};
        sh_next      = {1'b0, sh[7:1]};
        bit_cnt_next = bit_cnt + 3'd1;
        acc_cnt_next = acc_cnt + 4'd1;
        if (bit_cnt == 3'd7) begin
          byte_idx_next  = byte_idx + 5'd1;
          byte_done_next = 1'b1;
        end
        if (acc_cnt == 4'(CH_BITS - 1)) begin
          state_next = U_EMIT;
        end else if (bit_cnt == 3'd7) begin
          state_next = U_FETCH;
        end
      end
      U_EMIT: begin
        if (res_ready) begin
          acc_cnt_next = '0;
          ch_idx_next  = ch_idx + 4'd1;
          if (ch_idx == LAST_CH) begin
            state_next = U_IDLE;
          end else if (byte_done) begin
            state_next = U_FETCH;
          end else begin
            state_next = U_SHIFT;
          end
        end
      end
      default: begin
        state_next = U_IDLE;
      end
    endcase
  end

  assign rd_addr     = AW'(byte_idx);
  assign chan.valid  = (state == U_EMIT);
  assign chan.last   = (ch_idx == LAST_CH);
  assign chan.index  = ch_idx;
  assign chan.value  = acc;
  assign busy        = (state != U_IDLE);

endmodule

`default_nettype wire

// File: rtl/rc_link_frame_parser.sv
// A byte's status result passes through the S_EMIT state into the output register; a
// statistics result through S_STAT0, S_STAT1, S_STAT2 and S_STAT_EMIT, and the channels
// of a channels frame through the unpacker. Input is stalled while a result is pending,
// and a type or payload byte also holds it while the bit-serial CRC unit folds it in.
// A good channels frame emits 16 results.
// Reset is synchronous; the payload store's valid bits clear at once, no clearing pass.
`default_nettype none

module rc_link_frame_parser
  import rcl_pkg::*;
#(
  parameter int MAX_PAYLOAD = 60
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [2:0]       status,
  output logic [3:0]       channel_index,
  output logic [10:0]      channel_value,
  output logic [7:0]       rssi,
  output logic [7:0]       uplink_lq,
  output logic [31:0]      error_count,
  output logic             last
);

  localparam int         AW      = $clog2(MAX_PAYLOAD);
  localparam int         CW      = $clog2(MAX_PAYLOAD + 1);
  localparam logic [7:0] LEN_MAX = 8'(MAX_PAYLOAD + 2);

  ctl_state_t       state, state_next;
  phase_t           phase, phase_next;
  logic [CW-1:0]    payload_expected, payload_expected_next;
  logic [CW-1:0]    payload_received, payload_received_next;
  logic [7:0]       frame_kind_byte, frame_kind_byte_next;
  logic [31:0]      error_total;
  logic             err_inc;
  logic [1:0]       res_kind, res_kind_next;
  logic [2:0]       res_status, res_status_next;
  logic [7:0]       rssi_q, lq_q;
  logic             rssi_cap, lq_cap;
  logic [MAX_PAYLOAD-1:0] written;
  logic             vld_q;
  logic             accept;
  logic             out_free;

  // output load
  logic             out_load;
  logic [1:0]       ld_kind;
  logic [3:0]       ld_idx;
  logic [10:0]      ld_val;
  logic [7:0]       ld_rssi, ld_lq;
  logic             ld_last;

  // memory, CRC and unpacker hookup
  logic             ram_we;
  logic [AW-1:0]    ram_raddr, stat_addr, up_addr;
  logic [7:0]       ram_q, rd_data;
  crc_cmd_t         crc_cmd;
  logic [7:0]       crc_val;
  logic             crc_busy;
  logic             up_start, up_busy;
  chan_t            chan;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || crc_busy;
  assign out_free = !out_valid || !out_stall;

  rcl_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (payload_received[AW-1:0]),
    .wdata (rx_byte),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  rcl_crc8 u_crc (
    .clk  (clk),
    .rst  (rst),
    .cmd  (crc_cmd),
    .crc  (crc_val),
    .busy (crc_busy)
  );

  rcl_unpack #(
    .AW (AW)
  ) u_unpack (
    .clk       (clk),
    .rst       (rst),
    .start     (up_start),
    .res_ready (out_free && (state == S_CHAN)),
    .rd_data   (rd_data),
    .rd_addr   (up_addr),
    .chan      (chan),
    .busy      (up_busy)
  );

  assign ram_raddr = (state == S_CHAN) ? up_addr : stat_addr;
  // never-written entries read as zero
  assign rd_data   = vld_q ? ram_q : 8'h00;

  // written flags, valid of the read entry tracks the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (ram_we) begin
      written[payload_received[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    vld_q <= written[ram_raddr];
  end

  // control and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= PH_ADDR;
      payload_expected <= '0;
      payload_received <= '0;
      frame_kind_byte  <= '0;
      error_total      <= '0;
      res_kind         <= KIND_STATUS;
      res_status       <= ST_OK;
    end else begin
      state            <= state_next;
      phase            <= phase_next;
      payload_expected <= payload_expected_next;
      payload_received <= payload_received_next;
      frame_kind_byte  <= frame_kind_byte_next;
      res_kind         <= res_kind_next;
      res_status       <= res_status_next;
      if (err_inc && (error_total != ERR_MAX)) begin
        error_total <= error_total + 32'd1;
      end
    end
  end

  // statistics capture
  always_ff @(posedge clk) begin
    if (rssi_cap) begin
      rssi_q <= rd_data;
    end
    if (lq_cap) begin
      lq_q <= rd_data;
    end
  end

  // byte decode and result sequencing
  always_comb begin
    state_next            = state;
    phase_next            = phase;
    payload_expected_next = payload_expected;
    payload_received_next = payload_received;
    frame_kind_byte_next  = frame_kind_byte;
    res_kind_next         = res_kind;
    res_status_next       = res_status;
    err_inc               = 1'b0;
    ram_we                = 1'b0;
    crc_cmd               = '0;
    up_start              = 1'b0;
    stat_addr             = '0;
    rssi_cap              = 1'b0;
    lq_cap                = 1'b0;
    out_load              = 1'b0;
    ld_kind               = KIND_STATUS;
    ld_idx                = '0;
    ld_val                = '0;
    ld_rssi               = '0;
    ld_lq                 = '0;
    ld_last               = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_kind_next   = KIND_STATUS;
          res_status_next = ST_OK;
          state_next      = S_EMIT;
          unique case (phase)
            PH_ADDR: begin
              if (is_addr(rx_byte)) begin
                phase_next = PH_LEN;
              end else begin
                err_inc         = 1'b1;
                res_status_next = ST_BAD_ADDR;
              end
            end
            PH_LEN: begin
              payload_received_next = '0;
              if ((rx_byte >= 8'd2) && (rx_byte <= LEN_MAX)) begin
                payload_expected_next = CW'(rx_byte - 8'd2);
                phase_next            = PH_TYPE;
              end else begin
                err_inc               = 1'b1;
                payload_expected_next = '0;
                phase_next            = PH_ADDR;
                res_status_next       = ST_BAD_LEN;
              end
            end
            PH_TYPE: begin
              if (rx_byte < TYPE_LIMIT) begin
                frame_kind_byte_next = rx_byte;
                crc_cmd.start        = 1'b1;
                crc_cmd.init         = 1'b1;
                crc_cmd.data         = rx_byte;
                phase_next = (payload_expected == '0) ? PH_CRC : PH_PAYLOAD;
              end else begin
                err_inc               = 1'b1;
                payload_expected_next = '0;
                payload_received_next = '0;
                phase_next            = PH_ADDR;
                res_status_next       = ST_BAD_TYPE;
              end
            end
            PH_PAYLOAD: begin
              ram_we                = (payload_received < CW'(MAX_PAYLOAD));
              crc_cmd.start         = 1'b1;
              crc_cmd.data          = rx_byte;
              payload_received_next = payload_received + 1'b1;
              if (payload_received_next >= payload_expected) begin
                phase_next = PH_CRC;
              end
            end
            PH_CRC: begin
              payload_expected_next = '0;
              payload_received_next = '0;
              phase_next            = PH_ADDR;
              if (crc_val != rx_byte) begin
                err_inc         = 1'b1;
                res_status_next = ST_BAD_CRC;
              end else if (frame_kind_byte == TYPE_CHANNELS) begin
                up_start   = 1'b1;
                state_next = S_CHAN;
              end else if (frame_kind_byte == TYPE_LINK_STATS) begin
                state_next = S_STAT0;
              end else begin
                err_inc       = 1'b1;
                res_kind_next = KIND_UNKNOWN;
              end
            end
            default: begin
              payload_expected_next = '0;
              payload_received_next = '0;
              phase_next            = PH_ADDR;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_kind    = res_kind;
          state_next = S_IDLE;
        end
      end
      S_STAT0: begin
        stat_addr  = AW'(0);
        state_next = S_STAT1;
      end
      S_STAT1: begin
        stat_addr  = AW'(2);
        rssi_cap   = 1'b1;
        state_next = S_STAT2;
      end
      S_STAT2: begin
        lq_cap     = 1'b1;
        state_next = S_STAT_EMIT;
      end
      S_STAT_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          ld_kind    = KIND_STATS;
          ld_rssi    = rssi_q;
          ld_lq      = lq_q;
          state_next = S_IDLE;
        end
      end
      S_CHAN: begin
        if (chan.valid && out_free) begin
          out_load = 1'b1;
          ld_kind  = KIND_CHANNEL;
          ld_idx   = chan.index;
          ld_val   = chan.value;
          ld_last  = chan.last;
          if (chan.last) begin
            state_next = S_IDLE;
          end
        end else if (!up_busy) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind          <= ld_kind;
      status        <= (state == S_EMIT) ? res_status : ST_OK;
      channel_index <= ld_idx;
      channel_value <= ld_val;
      rssi          <= ld_rssi;
      uplink_lq     <= ld_lq;
      error_count   <= error_total;
      last          <= ld_last;
    end
  end

endmodule

`default_nettype wire

// File: rtl/rcl_checker.sv
// Port-level checks of the frame parser and their binding to the top level.
`default_nettype none

module rcl_checker
  import rcl_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [7:0]  rx_byte,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  kind,
  input wire logic [2:0]  status,
  input wire logic [3:0]  channel_index,
  input wire logic [10:0] channel_value,
  input wire logic [7:0]  rssi,
  input wire logic [7:0]  uplink_lq,
  input wire logic [31:0] error_count,
  input wire logic        last
);

  // a stalled input item holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(rx_byte))
    else $error("input changed while stalled");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(status)
      && $stable(channel_index) && $stable(channel_value) && $stable(rssi)
      && $stable(uplink_lq) && $stable(error_count) && $stable(last))
    else $error("result changed while stalled");

  // frame results always carry an ok status
  a_kind_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind != KIND_STATUS) |-> (status == ST_OK))
    else $error("frame result with error status");

  // channel burst ends exactly on the sixteenth channel
  a_chan_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == KIND_CHANNEL) |-> (last == (channel_index == LAST_CH)))
    else $error("channel last flag mismatch");

  // error count never goes down between shown results
  a_err_mono: assert property (@(posedge clk) disable iff (rst)
    out_valid && $past(out_valid) && !$past(rst) |-> (error_count >= $past(error_count)))
    else $error("error count decreased");

endmodule

bind rc_link_frame_parser rcl_checker u_rcl_checker (.*);

`default_nettype wire

// File: dv/tb_rc_link_frame_parser.sv
// Self-checking testbench of the radio-control link frame parser: directed and random byte streams.
`timescale 1ns / 100ps

module tb_rc_link_frame_parser;
  import rcl_pkg::*;

  localparam int MAX_PAYLOAD    = 60;
  localparam int BYTE_TARGET    = 460;
  localparam int HOLD_OFF       = 400;
  localparam int DRAIN_TAIL     = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PRINT_CAP      = 50;

  // One result item as seen on the output port
  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  status;
    logic [3:0]  chan_idx;
    logic [10:0] chan_val;
    logic [7:0]  rssi;
    logic [7:0]  lq;
    logic [31:0] errs;
    logic        last;
  } parse_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [2:0]  status;
  logic [3:0]  channel_index;
  logic [10:0] channel_value;
  logic [7:0]  rssi;
  logic [7:0]  uplink_lq;
  logic [31:0] error_count;
  logic        last;

  // Shared run control
  bit steady = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int mismatches = 0;

  // Parser state as predicted by the testbench
  phase_t        model_phase = PH_ADDR;
  logic [7:0]    model_store[MAX_PAYLOAD];
  int            model_len = 0;
  int            model_cnt = 0;
  logic [7:0]    model_type = 8'h00;
  logic [7:0]    model_crc = 8'h00;
  logic [31:0]   model_errors = 32'h0;
  parse_result_t parsed_results_due[$];

  rc_link_frame_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .status       (status),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .rssi         (rssi),
    .uplink_lq    (uplink_lq),
    .error_count  (error_count),
    .last         (last)
  );

  always #6 clk = ~clk;

  initial begin
    foreach (model_store[i]) model_store[i] = 8'h00;
  end

  // CRC-8, polynomial 0xD5, MSB first
  function automatic logic [7:0] crc8_d5(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  function automatic logic [7:0] pick_addr();
    case ($urandom_range(3))
      0: return ADDR_BROADCAST;
      1: return ADDR_RADIO;
      2: return ADDR_FC;
      default: return ADDR_RX;
    endcase
  endfunction

  task automatic bump_errors();
    if (model_errors != ERR_MAX) model_errors++;
  endtask

  // Advance the predicted parser by one byte and queue the results it causes
  task automatic parse_rx_byte(input logic [7:0] b);
    parse_result_t r;
    logic [175:0]  packed_chans;
    logic [2:0]    st;
    bit            frame_done;
    st = ST_OK;
    frame_done = 1'b0;
    r = '0;
    case (model_phase)
      PH_ADDR: begin
        if (b == ADDR_BROADCAST || b == ADDR_RADIO || b == ADDR_FC || b == ADDR_RX) begin
          model_phase = PH_LEN;
        end else begin
          bump_errors();
          st = ST_BAD_ADDR;
        end
      end
      PH_LEN: begin
        if (b >= 2 && b <= MAX_PAYLOAD + 2) begin
          model_len = b - 2;
          model_cnt = 0;
          model_phase = PH_TYPE;
        end else begin
          bump_errors();
          model_phase = PH_ADDR;
          st = ST_BAD_LEN;
        end
      end
      PH_TYPE: begin
        if (b < TYPE_LIMIT) begin
          model_type = b;
          model_crc = crc8_d5(8'h00, b);
          model_phase = (model_len == 0) ? PH_CRC : PH_PAYLOAD;
        end else begin
          bump_errors();
          model_phase = PH_ADDR;
          st = ST_BAD_TYPE;
        end
      end
      PH_PAYLOAD: begin
        if (model_cnt < MAX_PAYLOAD) model_store[model_cnt] = b;
        model_crc = crc8_d5(model_crc, b);
        model_cnt++;
        if (model_cnt >= model_len) model_phase = PH_CRC;
      end
      PH_CRC: begin
        model_phase = PH_ADDR;
        if (model_crc != b) begin
          bump_errors();
          st = ST_BAD_CRC;
        end else if (model_type == TYPE_CHANNELS) begin
          // sixteen 11-bit channels packed LSB first over the first 22 bytes
          for (int i = 0; i < 22; i++) packed_chans[8*i +: 8] = model_store[i];
          for (int i = 0; i < 16; i++) begin
            r = '0;
            r.kind = KIND_CHANNEL;
            r.chan_idx = 4'(i);
            r.chan_val = packed_chans[11*i +: 11];
            r.errs = model_errors;
            r.last = (4'(i) == LAST_CH);
            parsed_results_due.push_back(r);
          end
          frame_done = 1'b1;
        end else if (model_type == TYPE_LINK_STATS) begin
          r.kind = KIND_STATS;
          r.rssi = model_store[0];
          r.lq = model_store[2];
          r.errs = model_errors;
          r.last = 1'b1;
          parsed_results_due.push_back(r);
          frame_done = 1'b1;
        end else begin
          bump_errors();
          r.kind = KIND_UNKNOWN;
          r.errs = model_errors;
          r.last = 1'b1;
          parsed_results_due.push_back(r);
          frame_done = 1'b1;
        end
      end
      default: model_phase = PH_ADDR;
    endcase
    if (!frame_done) begin
      r = '0;
      r.kind = KIND_STATUS;
      r.status = st;
      r.errs = model_errors;
      r.last = 1'b1;
      parsed_results_due.push_back(r);
    end
  endtask

  // Offer one byte, with random idle cycles ahead of it, and wait for acceptance
  task automatic send_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] addr, input logic [7:0] ftype,
                            input logic [7:0] body[$], input bit crc_ok);
    logic [7:0] c;
    c = crc8_d5(8'h00, ftype);
    foreach (body[i]) c = crc8_d5(c, body[i]);
    if (!crc_ok) c = c ^ 8'($urandom_range(255, 1));
    send_byte(addr);
    send_byte(8'(body.size() + 2));
    send_byte(ftype);
    foreach (body[i]) send_byte(body[i]);
    send_byte(c);
  endtask

  task automatic random_body(output logic [7:0] body[$], input int n);
    body = {};
    repeat (n) body.push_back(8'($urandom_range(255)));
  endtask

  // Stop offering and let every due result come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (parsed_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Bad address, length and type bytes, length extremes
  task automatic test_header_errors();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ADDR_BROADCAST);
    send_byte(8'd0);
    send_byte(ADDR_RADIO);
    send_byte(8'd1);
    send_byte(ADDR_FC);
    send_byte(8'(MAX_PAYLOAD + 3));
    send_byte(ADDR_RX);
    send_byte(8'hFF);
    send_byte(ADDR_BROADCAST);
    send_byte(8'd2);
    send_byte(TYPE_LIMIT);
    send_byte(ADDR_RADIO);
    send_byte(8'd10);
    send_byte(8'hFF);
  endtask

  // Zero-payload frames: straight from type to crc, known types read a cleared store
  task automatic test_zero_payload();
    logic [7:0] none[$];
    none = {};
    send_frame(ADDR_FC, 8'h00, none, 1'b1);
    send_frame(ADDR_RX, TYPE_LIMIT - 8'd1, none, 1'b0);
    send_frame(ADDR_BROADCAST, TYPE_CHANNELS, none, 1'b1);
    send_frame(ADDR_RADIO, TYPE_LINK_STATS, none, 1'b1);
  endtask

  // Full channel frames, one with every value at its maximum and two random, with no idling on either side
  task automatic test_channels();
    logic [7:0] body[$];
    steady = 1'b1;
    body = {};
    repeat (22) body.push_back(8'hFF);
    send_frame(ADDR_FC, TYPE_CHANNELS, body, 1'b1);
    random_body(body, 22);
    send_frame(ADDR_BROADCAST, TYPE_CHANNELS, body, 1'b1);
    random_body(body, 22);
    send_frame(ADDR_RX, TYPE_CHANNELS, body, 1'b0);
    steady = 1'b0;
  endtask

  // Known frames shorter than their fields reuse what the store still holds
  task automatic test_short_frames();
    logic [7:0] body[$];
    random_body(body, 3);
    send_frame(ADDR_FC, TYPE_CHANNELS, body, 1'b1);
    random_body(body, 1);
    send_frame(ADDR_RADIO, TYPE_LINK_STATS, body, 1'b1);
    random_body(body, 10);
    send_frame(ADDR_FC, TYPE_LINK_STATS, body, 1'b1);
  endtask

  // Largest payloads the length field allows
  task automatic test_max_length();
    logic [7:0] body[$];
    random_body(body, MAX_PAYLOAD);
    send_frame(ADDR_BROADCAST, 8'h2A, body, 1'b1);
    random_body(body, MAX_PAYLOAD);
    send_frame(ADDR_FC, TYPE_CHANNELS, body, 1'b1);
  endtask

  // Receiver holds off while frames keep coming, so the parser fills and stalls
  task automatic test_backpressure();
    logic [7:0] body[$];
    steady = 1'b1;
    hold_req = HOLD_OFF;
    repeat (3) begin
      random_body(body, 22);
      send_frame(pick_addr(), TYPE_CHANNELS, body, 1'b1);
    end
    steady = 1'b0;
    wait_results_drained();
  endtask

  // Sender pauses until everything due has come out
  task automatic test_pause();
    logic [7:0] body[$];
    random_body(body, 10);
    send_frame(ADDR_FC, TYPE_LINK_STATS, body, 1'b1);
    wait_results_drained();
    random_body(body, 5);
    send_frame(ADDR_RX, 8'h08, body, 1'b1);
  endtask

  // Mostly well-formed frames with random content, the rest noise and broken headers
  task automatic test_random_stream();
    logic [7:0] body[$];
    logic [7:0] ftype;
    int         pick;
    int         n;
    while (bytes_sent < BYTE_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          ftype = TYPE_CHANNELS;
          n = ($urandom_range(99) < 80) ? 22 : $urandom_range(MAX_PAYLOAD);
        end else if (pick < 65) begin
          ftype = TYPE_LINK_STATS;
          n = ($urandom_range(99) < 80) ? 10 : $urandom_range(12);
        end else begin
          ftype = 8'($urandom_range(TYPE_LIMIT - 1));
          n = ($urandom_range(99) < 90) ? $urandom_range(16) : $urandom_range(MAX_PAYLOAD, 17);
        end
        random_body(body, n);
        send_frame(pick_addr(), ftype, body, $urandom_range(99) < 85);
      end else if (pick < 85) begin
        // raw noise, then random bytes until the parser looks for an address again
        send_byte(8'($urandom_range(255)));
        while (model_phase != PH_ADDR) send_byte(8'($urandom_range(255)));
      end else if (pick < 92) begin
        send_byte(pick_addr());
        if ($urandom_range(1)) send_byte(8'($urandom_range(1)));
        else send_byte(8'($urandom_range(255, MAX_PAYLOAD + 3)));
      end else begin
        send_byte(pick_addr());
        send_byte(8'($urandom_range(MAX_PAYLOAD + 2, 2)));
        send_byte(8'($urandom_range(255, TYPE_LIMIT)));
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compare each accepted result with the oldest one due
  always @(posedge clk) begin
    parse_result_t w;
    if (!rst && out_valid && !out_stall) begin
      if (parsed_results_due.size() == 0) begin
        report_mismatch("result with nothing due");
      end else begin
        w = parsed_results_due.pop_front();
        if (kind !== w.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind, w.kind));
        if (status !== w.status)
          report_mismatch($sformatf("status %0d, want %0d", status, w.status));
        if (channel_index !== w.chan_idx)
          report_mismatch($sformatf("channel_index %0d, want %0d", channel_index, w.chan_idx));
        if (channel_value !== w.chan_val)
          report_mismatch($sformatf("channel_value %0d, want %0d", channel_value, w.chan_val));
        if (rssi !== w.rssi)
          report_mismatch($sformatf("rssi %0d, want %0d", rssi, w.rssi));
        if (uplink_lq !== w.lq)
          report_mismatch($sformatf("uplink_lq %0d, want %0d", uplink_lq, w.lq));
        if (error_count !== w.errs)
          report_mismatch($sformatf("error_count %0d, want %0d", error_count, w.errs));
        if (last !== w.last)
          report_mismatch($sformatf("last %0d, want %0d", last, w.last));
      end
    end
  end

  // Receiver stall: random, or held for a counted stretch on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 17);
    end
  end

  // Watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_header_errors();
    test_zero_payload();
    test_channels();
    test_short_frames();
    test_max_length();
    test_backpressure();
    test_pause();
    test_random_stream();
    wait_results_drained();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: rc_link_frame_parser.f
rtl/rcl_pkg.sv
rtl/rcl_ram.sv
rtl/rcl_crc8.sv
rtl/rcl_unpack.sv
rtl/rc_link_frame_parser.sv
rtl/rcl_checker.sv
dv/tb_rc_link_frame_parser.sv
